>>> rtl/core/sorted_event_queue_core_defines.svh
// Assertion macros for the sorted event queue core.
`ifndef SORTED_EVENT_QUEUE_CORE_DEFINES_SVH
`define SORTED_EVENT_QUEUE_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define SEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define SEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/seq_pkg.sv
// Types and codes shared by the sorted event queue modules.
package seq_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_LIST   = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [15:0] target_id;
  } seq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] id;
    logic [4:0]  slot;
    logic [11:0] entry_year;
    logic [3:0]  entry_month;
    logic [4:0]  entry_day;
    logic [4:0]  entry_hour;
    logic        entry_valid;
    logic        last;
  } seq_out_t;

  // Sort key, year most significant.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
  } seq_key_t;

  localparam int KEY_W = $bits(seq_key_t);

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } seq_cell_op_t;

  typedef struct packed {
    seq_cell_op_t op;
    seq_key_t     key;
  } seq_cell_ctrl_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_LIST
  } seq_state_t;

endpackage

>>> rtl/core/seq_cell.sv
// One slot of the sorted table: holds a key and id and shifts to or from its neighbours.
module seq_cell import seq_pkg::*; #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16,
  parameter int IDX     = 0,
  localparam int CW     = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  seq_cell_ctrl_t     ctrl,
  input  logic [ID_BITS-1:0] new_id,
  input  logic [ID_BITS-1:0] want_id,
  input  logic [CW-1:0]      count,
  input  seq_key_t           left_key,
  input  logic [ID_BITS-1:0] left_id,
  input  seq_key_t           right_key,
  input  logic [ID_BITS-1:0] right_id,
  input  seq_key_t           head_key,
  input  logic [ID_BITS-1:0] head_id,
  input  logic               aoa_prev,
  input  logic               found_prev,
  output seq_key_t           key_q,
  output logic [ID_BITS-1:0] id_q,
  output logic               aoa,
  output logic               found,
  output logic               sel,
  output logic               hit
);

  seq_key_t           key_r, key_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic               occ, occ_next;

  always_comb begin
    occ      = CW'(IDX) < count;
    occ_next = CW'(IDX + 1) < count;
    // at or after the insert position: empty, or key not below the new one
    aoa      = !occ || (key_r >= ctrl.key);
    found    = found_prev || (occ && (id_r == want_id));
    sel      = aoa && !aoa_prev;
    hit      = found && !found_prev;
    key_nxt  = key_r;
    id_nxt   = id_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (aoa_prev) begin
          key_nxt = left_key;
          id_nxt  = left_id;
        end else if (aoa) begin
          key_nxt = ctrl.key;
          id_nxt  = new_id;
        end
      end
      CELL_DELETE: begin
        if (found) begin
          key_nxt = right_key;
          id_nxt  = right_id;
        end
      end
      CELL_ROTATE: begin
        // last occupied slot wraps round to take the head
        if (occ_next) begin
          key_nxt = right_key;
          id_nxt  = right_id;
        end else if (occ) begin
          key_nxt = head_key;
          id_nxt  = head_id;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    id_r  <= id_nxt;
  end

  assign key_q = key_r;
  assign id_q  = id_r;

endmodule

>>> rtl/core/sorted_event_queue_core.sv
// Top level of the sorted event queue: chain of table cells, request control and result register.
//
// Events sit in a row of DEPTH cells kept in ascending (year, month, day, hour) order; a new
// event goes ahead of the first entry whose key is not below its own and takes the next id of
// an ID_BITS wide wrapping counter. On an insert or delete request every cell compares
// against the request at once and the row shifts by one place in the same cycle.
// A list request gives one result per stored entry (one result for an empty table): the row
// rotates one place per emitted result, presenting each entry at the head cell in turn, and
// is back in its original order when the last result leaves. One result register sits on
// the output; a new request is taken when that register is empty or being emptied in the
// same cycle, and not while a list is running. Requests with an unused code produce no
// result. The table needs no clearing after reset: only cells below the entry count are read.
`include "sorted_event_queue_core_defines.svh"

module sorted_event_queue_core import seq_pkg::*; #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  seq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output seq_out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  seq_state_t         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [ID_BITS-1:0] next_id_r, next_id_nxt;
  logic [IW-1:0]      list_idx_r, list_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  seq_out_t           out_data_r, out_data_nxt;

  seq_cell_ctrl_t     cell_ctrl;
  seq_key_t           req_key;
  logic [ID_BITS-1:0] want_id;

  seq_key_t           cell_key [DEPTH];
  logic [ID_BITS-1:0] cell_id  [DEPTH];
  logic [DEPTH-1:0]   aoa, found, sel, hit;

  logic               out_free, in_acc, list_last, full, load;
  logic [IW-1:0]      ins_slot, del_slot;
  logic [KEY_W-1:0]   del_key;
  logic [ID_BITS-1:0] del_id;
  seq_out_t           res;

  assign req_key = '{year: in_data.year, month: in_data.month,
                     day: in_data.day, hour: in_data.hour};
  assign want_id = ID_BITS'(in_data.target_id);

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    seq_key_t           l_key, r_key;
    logic [ID_BITS-1:0] l_id, r_id;
    logic               a_prev, f_prev;

    if (i == 0) begin : g_first
      assign l_key  = cell_key[0];
      assign l_id   = cell_id[0];
      assign a_prev = 1'b0;
      assign f_prev = 1'b0;
    end else begin : g_mid
      assign l_key  = cell_key[i-1];
      assign l_id   = cell_id[i-1];
      assign a_prev = aoa[i-1];
      assign f_prev = found[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_key = cell_key[i];
      assign r_id  = cell_id[i];
    end else begin : g_inner
      assign r_key = cell_key[i+1];
      assign r_id  = cell_id[i+1];
    end

    seq_cell #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS),
      .IDX     (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .new_id     (next_id_r),
      .want_id    (want_id),
      .count      (count_r),
      .left_key   (l_key),
      .left_id    (l_id),
      .right_key  (r_key),
      .right_id   (r_id),
      .head_key   (cell_key[0]),
      .head_id    (cell_id[0]),
      .aoa_prev   (a_prev),
      .found_prev (f_prev),
      .key_q      (cell_key[i]),
      .id_q       (cell_id[i]),
      .aoa        (aoa[i]),
      .found      (found[i]),
      .sel        (sel[i]),
      .hit        (hit[i])
    );
  end

  // gather the chosen slot and the removed entry from the one-hot selects
  always_comb begin
    ins_slot = '0;
    del_slot = '0;
    del_key  = '0;
    del_id   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ins_slot = ins_slot | (IW'(i) & {IW{sel[i]}});
      del_slot = del_slot | (IW'(i) & {IW{hit[i]}});
      del_key  = del_key | (KEY_W'(cell_key[i]) & {KEY_W{hit[i]}});
      del_id   = del_id | (cell_id[i] & {ID_BITS{hit[i]}});
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r == SEQ_LIST) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign full      = (count_r == CW'(DEPTH));
  assign list_last = ((CW'(list_idx_r) + CW'(1)) == count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (in_acc && (in_data.func == FUNC_LIST) && (count_r > CW'(1))) begin
          state_nxt = SEQ_LIST;
        end
      end
      SEQ_LIST: begin
        if (out_free && list_last) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cell_ctrl    = '{op: CELL_HOLD, key: req_key};
    load         = 1'b0;
    res          = '0;
    count_nxt    = count_r;
    next_id_nxt  = next_id_r;
    list_idx_nxt = list_idx_r;
    case (state_r)
      SEQ_IDLE: begin
        if (in_acc) begin
          case (in_data.func)
            FUNC_INSERT: begin
              load     = 1'b1;
              res.last = 1'b1;
              if (full) begin
                res.status = STATUS_FULL;
              end else begin
                cell_ctrl.op    = CELL_INSERT;
                res.status      = STATUS_OK;
                res.id          = 16'(32'(next_id_r));
                res.slot        = 5'(ins_slot);
                res.entry_year  = in_data.year;
                res.entry_month = in_data.month;
                res.entry_day   = in_data.day;
                res.entry_hour  = in_data.hour;
                res.entry_valid = 1'b1;
                count_nxt       = count_r + CW'(1);
                next_id_nxt     = next_id_r + ID_BITS'(1);
              end
            end
            FUNC_DELETE: begin
              load     = 1'b1;
              res.last = 1'b1;
              if (found[DEPTH-1]) begin
                cell_ctrl.op    = CELL_DELETE;
                res.status      = STATUS_OK;
                res.id          = 16'(32'(del_id));
                res.slot        = 5'(del_slot);
                {res.entry_year, res.entry_month, res.entry_day, res.entry_hour} = del_key;
                res.entry_valid = 1'b1;
                count_nxt       = count_r - CW'(1);
              end else begin
                res.status = STATUS_MISS;
                res.id     = in_data.target_id;
              end
            end
            FUNC_LIST: begin
              load = 1'b1;
              if (count_r == '0) begin
                res.last = 1'b1;
              end else begin
                cell_ctrl.op    = CELL_ROTATE;
                res.status      = STATUS_OK;
                res.id          = 16'(32'(cell_id[0]));
                res.slot        = '0;
                res.entry_year  = cell_key[0].year;
                res.entry_month = cell_key[0].month;
                res.entry_day   = cell_key[0].day;
                res.entry_hour  = cell_key[0].hour;
                res.entry_valid = 1'b1;
                res.last        = (count_r == CW'(1));
                list_idx_nxt    = IW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      SEQ_LIST: begin
        if (out_free) begin
          load            = 1'b1;
          cell_ctrl.op    = CELL_ROTATE;
          res.status      = STATUS_OK;
          res.id          = 16'(32'(cell_id[0]));
          res.slot        = 5'(list_idx_r);
          res.entry_year  = cell_key[0].year;
          res.entry_month = cell_key[0].month;
          res.entry_day   = cell_key[0].day;
          res.entry_hour  = cell_key[0].hour;
          res.entry_valid = 1'b1;
          res.last        = list_last;
          list_idx_nxt    = list_idx_r + IW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      count_r     <= '0;
      next_id_r   <= '0;
      list_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      list_idx_r  <= list_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SEQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "entry count beyond depth")
  `SEQ_ASSERT_NOW(a_ins_onehot, cell_ctrl.op == CELL_INSERT, $onehot(sel), "insert slot not unique")
  `SEQ_ASSERT_NOW(a_del_onehot0, 1'b1, $onehot0(hit), "more than one delete hit")
  `SEQ_ASSERT_NOW(a_list_stall, state_r == SEQ_LIST, in_stall, "request taken during list")
  `SEQ_ASSERT_NEXT(a_ins_count, cell_ctrl.op == CELL_INSERT, count_r == $past(count_r) + CW'(1), "insert did not grow count")

endmodule

>>> bench/sorted_event_queue_core_tb.sv
// Self-checking bench for the sorted event queue core: directed and random requests.
`timescale 1ns / 100ps

module sorted_event_queue_core_tb;
  import seq_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 340;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  seq_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  seq_out_t out_data;

  sorted_event_queue_core #(
    .DEPTH(TABLE_DEPTH),
    .ID_BITS(16)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted contents of the event table
  seq_key_t ev_key [TABLE_DEPTH];
  logic [15:0] ev_id [TABLE_DEPTH];
  int ev_count = 0;
  logic [15:0] ev_next_id = '0;

  seq_in_t request_backlog [$];
  seq_out_t pending_results [$];

  bit no_idle = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int results_checked = 0;
  int requests_taken = 0;
  int full_refusals = 0;
  int unknown_deletes = 0;
  int list_walks = 0;
  seq_out_t want;

  function automatic int idle_span();
    int r;
    begin
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
    end
  endfunction

  function automatic seq_key_t random_key();
    seq_key_t k;
    int pick;
    begin
      pick = $urandom_range(0, 99);
      if (pick < 15 && ev_count > 0) begin
        k = ev_key[$urandom_range(0, ev_count - 1)];
      end else if (pick < 30) begin
        // out-of-range parts are legal and sort as plain numbers
        k.year = 12'($urandom_range(0, 4095));
        k.month = 4'($urandom_range(0, 15));
        k.day = 5'($urandom_range(0, 31));
        k.hour = 5'($urandom_range(0, 31));
      end else begin
        k.year = 12'($urandom_range(0, 4095));
        k.month = 4'($urandom_range(1, 12));
        k.day = 5'($urandom_range(1, 31));
        k.hour = 5'($urandom_range(0, 23));
      end
      return k;
    end
  endfunction

  function automatic seq_in_t make_request(input logic [1:0] op, input seq_key_t k,
                                           input logic [15:0] tgt);
    seq_in_t r;
    begin
      r.func = op;
      r.year = k.year;
      r.month = k.month;
      r.day = k.day;
      r.hour = k.hour;
      r.target_id = tgt;
      return r;
    end
  endfunction

  function automatic string describe(input seq_out_t o);
    return $sformatf("status %0d id %0d slot %0d key %0d-%0d-%0d h%0d valid %0b last %0b",
                     o.status, o.id, o.slot, o.entry_year, o.entry_month, o.entry_day,
                     o.entry_hour, o.entry_valid, o.last);
  endfunction

  // Apply one accepted request to the table copy and queue the results it causes.
  task automatic advance_event_table(input seq_in_t r);
    seq_key_t k;
    seq_out_t o;
    int pos;
    int i;
    begin
      k.year = r.year;
      k.month = r.month;
      k.day = r.day;
      k.hour = r.hour;
      o = '0;
      o.last = 1'b1;
      requests_taken++;
      case (r.func)
        FUNC_INSERT: begin
          if (ev_count >= TABLE_DEPTH) begin
            o.status = STATUS_FULL;
            full_refusals++;
            pending_results.push_back(o);
          end else begin
            pos = ev_count;
            for (i = 0; i < ev_count; i++) begin
              if (pos == ev_count && ev_key[i] >= k) pos = i;
            end
            for (i = ev_count; i > pos; i--) begin
              ev_key[i] = ev_key[i - 1];
              ev_id[i] = ev_id[i - 1];
            end
            ev_key[pos] = k;
            ev_id[pos] = ev_next_id;
            ev_count++;
            o.status = STATUS_OK;
            o.id = ev_next_id;
            o.slot = 5'(pos);
            o.entry_year = k.year;
            o.entry_month = k.month;
            o.entry_day = k.day;
            o.entry_hour = k.hour;
            o.entry_valid = 1'b1;
            pending_results.push_back(o);
            ev_next_id = ev_next_id + 16'd1;
          end
        end
        FUNC_DELETE: begin
          pos = -1;
          for (i = 0; i < ev_count; i++) begin
            if (pos < 0 && ev_id[i] == r.target_id) pos = i;
          end
          if (pos < 0) begin
            o.status = STATUS_MISS;
            o.id = r.target_id;
            unknown_deletes++;
          end else begin
            o.status = STATUS_OK;
            o.id = ev_id[pos];
            o.slot = 5'(pos);
            o.entry_year = ev_key[pos].year;
            o.entry_month = ev_key[pos].month;
            o.entry_day = ev_key[pos].day;
            o.entry_hour = ev_key[pos].hour;
            o.entry_valid = 1'b1;
            for (i = pos; i + 1 < ev_count; i++) begin
              ev_key[i] = ev_key[i + 1];
              ev_id[i] = ev_id[i + 1];
            end
            ev_count--;
          end
          pending_results.push_back(o);
        end
        FUNC_LIST: begin
          list_walks++;
          if (ev_count == 0) pending_results.push_back(o);
          for (i = 0; i < ev_count; i++) begin
            o.status = STATUS_OK;
            o.id = ev_id[i];
            o.slot = 5'(i);
            o.entry_year = ev_key[i].year;
            o.entry_month = ev_key[i].month;
            o.entry_day = ev_key[i].day;
            o.entry_hour = ev_key[i].hour;
            o.entry_valid = 1'b1;
            o.last = (i + 1 == ev_count);
            pending_results.push_back(o);
          end
        end
        default: begin
          // unused code: no result, no state change
          requests_taken--;
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    while (request_backlog.size() > 0 || in_valid || pending_results.size() > 0)
      @(negedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) advance_event_table(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (request_backlog.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= request_backlog.pop_front();
          gap_left <= idle_span();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: %s", $time, describe(out_data));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(out_data));
            end
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        if (!no_idle && $urandom_range(0, 99) < 20) stall_left <= idle_span();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_LIMIT, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    seq_key_t k;
    logic [15:0] tgt;
    logic [1:0] op;
    int counted;
    int step;
    int r;
    bit filling;

    // directed: empty table, extremes, ties, full table, head/tail/middle removal
    request_backlog.push_back(make_request(FUNC_LIST, '0, '0));
    request_backlog.push_back(make_request(FUNC_DELETE, '0, 16'hFFFF));
    request_backlog.push_back(make_request(FUNC_UNUSED, '1, '1));
    request_backlog.push_back(make_request(FUNC_INSERT, '0, '0));
    request_backlog.push_back(make_request(FUNC_INSERT, '1, '1));
    k = {12'd2024, 4'd6, 5'd15, 5'd12};
    request_backlog.push_back(make_request(FUNC_INSERT, k, 16'h5555));
    request_backlog.push_back(make_request(FUNC_INSERT, k, 16'hAAAA));
    k = {12'd4095, 4'd12, 5'd31, 5'd23};
    request_backlog.push_back(make_request(FUNC_INSERT, k, '0));
    k = {12'd0, 4'd1, 5'd1, 5'd0};
    request_backlog.push_back(make_request(FUNC_INSERT, k, '0));
    repeat (10) request_backlog.push_back(make_request(FUNC_INSERT, random_key(), '0));
    request_backlog.push_back(make_request(FUNC_INSERT, k, '0));
    request_backlog.push_back(make_request(FUNC_LIST, '0, '0));
    request_backlog.push_back(make_request(FUNC_DELETE, '0, 16'd2));
    request_backlog.push_back(make_request(FUNC_DELETE, '0, 16'd1));
    request_backlog.push_back(make_request(FUNC_DELETE, '0, 16'd0));
    request_backlog.push_back(make_request(FUNC_DELETE, '0, 16'hABCD));
    request_backlog.push_back(make_request(FUNC_LIST, '0, '0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait_drained();

    counted = 0;
    step = 0;
    filling = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      while (request_backlog.size() > 1) @(negedge clk);
      // alternate between filling and draining the table
      if (step % 40 == 0) begin
        filling = !filling;
        no_idle = ($urandom_range(0, 3) == 0);
      end
      step++;
      r = $urandom_range(0, 99);
      if (r < 4) op = FUNC_UNUSED;
      else if (r < 18) op = FUNC_LIST;
      else if (r < (filling ? 75 : 40)) op = FUNC_INSERT;
      else op = FUNC_DELETE;
      tgt = 16'($urandom);
      if (op == FUNC_DELETE && ev_count > 0 && $urandom_range(0, 4) != 0)
        tgt = ev_id[$urandom_range(0, ev_count - 1)];
      request_backlog.push_back(make_request(op, random_key(), tgt));
      if (op != FUNC_UNUSED) counted++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Run covered %0d requests: %0d refused inserts, %0d unknown-id deletes, %0d lists.",
             requests_taken, full_refusals, unknown_deletes, list_walks);
    $display("Checked %0d results through fill and drain phases; %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sorted_event_queue_core.f
+incdir+rtl/core
rtl/core/seq_pkg.sv
rtl/core/seq_cell.sv
rtl/core/sorted_event_queue_core.sv
bench/sorted_event_queue_core_tb.sv
